FILE: sv/sound_channel_sample_generator_assert.svh
// Assertion macros for the sound channel sample generator.
// Used by the top level only; needs a clock and active-low reset argument.
`ifndef SOUND_CHANNEL_SAMPLE_GENERATOR_ASSERT_SVH
`define SOUND_CHANNEL_SAMPLE_GENERATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SCSG_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SCSG_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: sv/scsg_pkg.sv
// Package for the sound channel sample generator: types, codes, step table.
// No dependencies.
package scsg_pkg;
    localparam int STEP_ENTRIES = 89;
    localparam logic [6:0] INDEX_MAX = 7'd88;
    localparam logic [14:0] NOISE_SEED = 15'h7FFF;
    localparam logic [14:0] NOISE_TAP = 15'h6000;

    typedef enum logic [2:0] {
        FMT_PCM8 = 3'd0, FMT_PCM16 = 3'd1, FMT_ADPCM = 3'd2,
        FMT_SQUARE = 3'd3, FMT_NOISE = 3'd4
    } t_format;

    localparam logic [1:0] RPT_LOOP = 2'd1;
    localparam logic [1:0] RPT_ONESHOT = 2'd2;

    localparam logic [2:0] REG_FORMAT = 3'd0;
    localparam logic [2:0] REG_LOOP_START = 3'd1;
    localparam logic [2:0] REG_LENGTH = 3'd2;
    localparam logic [2:0] REG_REPEAT = 3'd3;
    localparam logic [2:0] REG_VOLUME = 3'd4;
    localparam logic [2:0] REG_SHIFT = 3'd5;
    localparam logic [2:0] REG_PAN = 3'd6;
    localparam logic [2:0] REG_DUTY = 3'd7;

    typedef struct packed {
        logic        func;
        logic [15:0] fetch_data;
        logic [15:0] start_sample;
        logic [6:0]  start_index;
    } t_in;

    typedef struct packed {
        logic [15:0] left_sample;
        logic [15:0] right_sample;
        logic [15:0] mono_sample;
        logic [24:0] next_offset;
        logic        running;
    } t_out;

    typedef struct packed {
        logic load;    // capture input item
        logic decode;  // produce sample and advance state
        logic scale;   // volume and pan
    } t_cmd;

    function automatic logic [14:0] step_lookup(input logic [6:0] idx);
        logic [14:0] t [0:STEP_ENTRIES-1];
        t = '{15'h0007, 15'h0008, 15'h0009, 15'h000A, 15'h000B, 15'h000C, 15'h000D,
              15'h000E, 15'h0010, 15'h0011, 15'h0013, 15'h0015, 15'h0017, 15'h0019,
              15'h001C, 15'h001F, 15'h0022, 15'h0025, 15'h0029, 15'h002D, 15'h0032,
              15'h0037, 15'h003C, 15'h0042, 15'h0049, 15'h0050, 15'h0058, 15'h0061,
              15'h006B, 15'h0076, 15'h0082, 15'h008F, 15'h009D, 15'h00AD, 15'h00BE,
              15'h00D1, 15'h00E6, 15'h00FD, 15'h0117, 15'h0133, 15'h0151, 15'h0173,
              15'h0198, 15'h01C1, 15'h01EE, 15'h0220, 15'h0256, 15'h0292, 15'h02D4,
              15'h031C, 15'h036C, 15'h03C3, 15'h0424, 15'h048E, 15'h0502, 15'h0583,
              15'h0610, 15'h06AB, 15'h0756, 15'h0812, 15'h08E0, 15'h09C3, 15'h0ABD,
              15'h0BD0, 15'h0CFF, 15'h0E4C, 15'h0FBA, 15'h114C, 15'h1307, 15'h14EE,
              15'h1706, 15'h1954, 15'h1BDC, 15'h1EA5, 15'h21B6, 15'h2515, 15'h28CA,
              15'h2CDF, 15'h315B, 15'h364B, 15'h3BB9, 15'h41B2, 15'h4844, 15'h4F7E,
              15'h5771, 15'h602F, 15'h69CE, 15'h7462, 15'h7FFF};
        if (idx > INDEX_MAX) return t[INDEX_MAX];
        return t[idx];
    endfunction
endpackage

FILE: sv/scsg_stream_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing; payload type given by parameter.
interface scsg_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/scsg_ctrl.sv
// Controller: sequences load, decode, scale and output hold per item.
// Depends on scsg_pkg.
module scsg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output scsg_pkg::t_cmd o_cmd
);
    import scsg_pkg::*;
    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_SCALE, S_OUT} t_state;
    t_state r_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.decode = (r_state == S_DECODE);
    assign o_cmd.scale  = (r_state == S_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_DECODE;
                S_DECODE: r_state <= S_SCALE;
                S_SCALE:  r_state <= S_OUT;
                S_OUT:    if (i_out_ready) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/scsg_datapath.sv
// Datapath: channel state, sample decode, volume and pan scaling.
// Depends on scsg_pkg.
module scsg_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [21:0]    i_cfg_data,
    input  scsg_pkg::t_cmd i_cmd,
    input  scsg_pkg::t_in  i_item,
    output scsg_pkg::t_out o_result
);
    import scsg_pkg::*;

    logic [2:0]  r_format;
    logic [15:0] r_loop_start;
    logic [21:0] r_length;
    logic [1:0]  r_repeat;
    logic [6:0]  r_volume, r_pan;
    logic [1:0]  r_shift;
    logic [2:0]  r_duty;

    logic [24:0] r_offset;
    logic        r_running, r_high;
    logic [15:0] r_pred, r_loop_pred;
    logic [6:0]  r_index, r_loop_index;
    logic [2:0]  r_phase;
    logic [14:0] r_noise;

    t_in         r_item;
    logic        r_emit;
    logic signed [15:0] r_s, r_m;

    // decode
    logic [24:0] loop_begin, loop_end, n_offset, adv;
    logic signed [15:0] n_s, n_pred_step;
    logic [6:0]  n_index_step;
    logic [3:0]  nib;
    logic [14:0] step;
    logic [18:0] diff;
    logic signed [17:0] sum;
    logic signed [7:0] idx_sum;
    logic signed [7:0] delta;

    always_comb begin
        loop_begin = {7'd0, r_loop_start, 2'b00};
        loop_end   = loop_begin + {1'b0, r_length, 2'b00};
        nib  = r_high ? r_item.fetch_data[7:4] : r_item.fetch_data[3:0];
        step = step_lookup(r_index);
        diff = ({15'd0, nib[2:0], 1'b1} * {4'd0, step}) >> 3;
        sum  = nib[3] ? $signed({{2{r_pred[15]}}, r_pred}) - $signed({1'b0, diff[16:0]})
                      : $signed({{2{r_pred[15]}}, r_pred}) + $signed({1'b0, diff[16:0]});
        n_pred_step = (sum > 18'sd32767) ? 16'sh7FFF :
                      (sum < -18'sd32768) ? 16'sh8000 : sum[15:0];
        delta = nib[2] ? $signed({5'd0, nib[1:0], 1'b0}) + 8'sd2 : -8'sd1;
        idx_sum = $signed({1'b0, r_index}) + delta;
        n_index_step = (idx_sum < 0) ? 7'd0 :
                       (idx_sum > $signed({1'b0, INDEX_MAX})) ? INDEX_MAX : idx_sum[6:0];
        adv = 25'd0;
        n_s = '0;
        case (r_format)
            FMT_PCM8:  begin n_s = {r_item.fetch_data[7:0], 8'd0}; adv = 25'd1; end
            FMT_PCM16: begin n_s = r_item.fetch_data; adv = 25'd2; end
            FMT_ADPCM: begin n_s = n_pred_step; adv = {24'd0, r_high}; end
            FMT_SQUARE: n_s = (r_phase <= r_duty) ? 16'sh7FFF : 16'sh8000;
            FMT_NOISE:  n_s = r_noise[0] ? 16'sh8000 : 16'sh7FFF;
            default: n_s = '0;
        endcase
        n_offset = r_offset + adv;
    end

    // scale
    logic signed [15:0] shifted;
    logic signed [23:0] vprod;
    logic signed [15:0] m_val;
    logic signed [23:0] lprod, rprod;
    always_comb begin
        case (r_shift)
            2'd0: shifted = r_s;
            2'd1: shifted = r_s >>> 1;
            2'd2: shifted = r_s >>> 2;
            default: shifted = r_s >>> 4;
        endcase
        vprod = shifted * $signed({1'b0, r_volume});
        m_val = vprod[22:7];
        lprod = r_m * $signed({1'b0, 8'd128 - {1'b0, r_pan}});
        rprod = r_m * $signed({2'b0, r_pan});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= '0; r_loop_start <= '0; r_length <= '0; r_repeat <= '0;
            r_volume <= '0; r_shift <= '0; r_pan <= 7'd64; r_duty <= '0;
            r_offset <= '0; r_running <= 1'b0; r_high <= 1'b0;
            r_pred <= '0; r_index <= '0; r_loop_pred <= '0; r_loop_index <= '0;
            r_phase <= '0; r_noise <= NOISE_SEED; r_emit <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FORMAT:     r_format <= i_cfg_data[2:0];
                    REG_LOOP_START: r_loop_start <= i_cfg_data[15:0];
                    REG_LENGTH:     r_length <= i_cfg_data;
                    REG_REPEAT:     r_repeat <= i_cfg_data[1:0];
                    REG_VOLUME:     r_volume <= i_cfg_data[6:0];
                    REG_SHIFT:      r_shift <= i_cfg_data[1:0];
                    REG_PAN:        r_pan <= i_cfg_data[6:0];
                    REG_DUTY:       r_duty <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cmd.decode) begin
                r_emit <= 1'b0;
                r_s <= '0;
                if (r_item.func) begin
                    r_offset <= '0; r_running <= 1'b1; r_high <= 1'b0;
                    r_pred <= r_item.start_sample;
                    r_index <= (r_item.start_index > INDEX_MAX) ? INDEX_MAX
                                                                : r_item.start_index;
                    r_phase <= '0; r_noise <= NOISE_SEED;
                end else if (r_running) begin
                    r_emit <= 1'b1;
                    r_s <= n_s;
                    if (r_offset == loop_begin && !r_high) begin
                        r_loop_pred <= r_pred; r_loop_index <= r_index;
                    end
                    if (r_format == FMT_ADPCM) begin
                        r_high <= !r_high;
                        r_pred <= n_pred_step; r_index <= n_index_step;
                    end
                    if (r_format == FMT_SQUARE) r_phase <= r_phase + 3'd1;
                    if (r_format == FMT_NOISE)
                        r_noise <= r_noise[0] ? ((r_noise >> 1) ^ NOISE_TAP) : (r_noise >> 1);
                    r_offset <= n_offset;
                    if (n_offset >= loop_end) begin
                        if (r_repeat == RPT_LOOP) begin
                            r_offset <= loop_begin;
                            r_pred <= (r_offset == loop_begin && !r_high) ? r_pred : r_loop_pred;
                            r_index <= (r_offset == loop_begin && !r_high) ? r_index
                                                                           : r_loop_index;
                        end else if (r_repeat == RPT_ONESHOT) begin
                            r_running <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.scale) r_m <= r_emit ? m_val : 16'sd0;
    end

    assign o_result.left_sample  = lprod[22:7];
    assign o_result.right_sample = rprod[22:7];
    assign o_result.mono_sample  = r_m;
    assign o_result.next_offset  = r_offset;
    assign o_result.running      = r_running;
endmodule

FILE: sv/sound_channel_sample_generator.sv
// Top level of the sound channel sample generator.
// Depends on scsg_pkg, scsg_stream_if, scsg_ctrl, scsg_datapath and the assert header.
//
// Usage: one input item per sample period on in_ch (func, fetch_data,
// start_sample, start_index); one result item per input on out_ch.
// An item is transferred when valid and ready are both high.
// After the input transfer the item is captured, decoded and scaled, and the
// result is then held valid until taken; input ready rises again in the
// cycle after the result transfer, so under the controller's four-state
// sequence a new item is not taken until the last result has gone.
// The pan multiplies read the held mono sample, so the output stays
// stable while the receiver stalls; no input is taken during a stall.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are applied at once;
// the user must make them only while the block is idle, which it does not enforce.
// Synchronous active-low reset clears channel state, pan to 64, noise
// register to all ones.
`include "sound_channel_sample_generator_assert.svh"
module sound_channel_sample_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data,
    scsg_stream_if.sink   in_ch,
    scsg_stream_if.source out_ch
);
    import scsg_pkg::*;
    t_cmd cmd;

    scsg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_cmd(cmd)
    );

    scsg_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .i_item(in_ch.data), .o_result(out_ch.data)
    );

    `SCSG_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, in_ch.ready, !out_ch.valid)
    `SCSG_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.data))
    `SCSG_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, cmd.decode && u_dp.r_item.func,
        out_ch.data.running)
endmodule
